### hw/rtl/complex_arith_unit_macros.svh
// assertion macros for the complex arithmetic unit checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define CAU_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("cau check failed");

// antecedent holds, consequent holds in the cycle after
`define CAU_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("cau check failed");

`endif

### hw/rtl/cau_pkg.sv
// shared types, widths and helpers for the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int FracBits  = 16;
  localparam int DataW     = 32;
  localparam int ProdW     = 2 * DataW;
  localparam int SumW      = ProdW + 1;
  localparam int MagW      = ProdW;
  localparam int QuoW      = DataW + 1;
  localparam int NumW      = MagW + FracBits;
  localparam int CmpW      = MagW + QuoW;
  localparam int DivStages = QuoW + 1;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StDivZero  = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [DataW-1:0] a_re;
    logic signed [DataW-1:0] a_im;
    logic signed [DataW-1:0] b_re;
    logic signed [DataW-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] res_re;
    logic signed [DataW-1:0] res_im;
    status_e                 status;
  } cau_out_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic                    div_zero;
    logic signed [DataW-1:0] a_re;
    logic signed [DataW-1:0] a_im;
    logic signed [DataW-1:0] b_re;
    logic signed [DataW-1:0] b_im;
  } cau_item_t;

  typedef struct packed {
    logic             valid;
    cmd_e             cmd;
    logic             div_zero;
    logic             neg_re;
    logic             neg_im;
    logic [DataW-1:0] pre_re;
    logic [DataW-1:0] pre_im;
    logic             pre_ovf;
  } cau_side_t;

  typedef struct packed {
    logic [DataW-1:0] val;
    logic             ovf;
  } cau_sat_t;

  localparam logic [QuoW-1:0] NegLim = QuoW'(1) << (DataW - 1);

  // clamp a sign/magnitude value to the signed word range
  function automatic cau_sat_t sat_mag(input logic neg, input logic big,
                                       input logic [QuoW-1:0] mag);
    cau_sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (big || (mag > NegLim)) begin
        r.val = {1'b1, {(DataW-1){1'b0}}};
        r.ovf = 1'b1;
      end else begin
        r.val = DataW'(QuoW'(0) - mag);
      end
    end else begin
      if (big || (mag[QuoW-1:DataW-1] != '0)) begin
        r.val = {1'b0, {(DataW-1){1'b1}}};
        r.ovf = 1'b1;
      end else begin
        r.val = mag[DataW-1:0];
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/cau_front.sv
// front end: accepts input words, flags divide by zero, holds them in a
// two-entry queue for the back end; uses cau_pkg
module cau_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cau_pkg::cau_in_t    in_i,
  input  logic                pop_i,
  output logic                item_valid_o,
  output cau_pkg::cau_item_t  item_o
);

  cau_pkg::cau_item_t mem_q [2];
  cau_pkg::cau_item_t cls;
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push;
  logic               pop;

  always_comb begin
    cls.cmd      = in_i.command;
    cls.div_zero = (in_i.command == cau_pkg::CmdDiv) && (in_i.b_re == '0) &&
                   (in_i.b_im == '0);
    cls.a_re     = in_i.a_re;
    cls.a_im     = in_i.a_im;
    cls.b_re     = in_i.b_re;
    cls.b_im     = in_i.b_im;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ push;
      rd_ptr_q <= rd_ptr_q ^ pop;
      cnt_q    <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/cau_div.sv
// pipelined restoring divider, two lanes sharing one denominator,
// one quotient bit per stage after the head stage; uses cau_pkg
module cau_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  cau_pkg::cau_side_t             side_i,
  input  logic [cau_pkg::MagW-1:0]       num_re_i,
  input  logic [cau_pkg::MagW-1:0]       num_im_i,
  input  logic [cau_pkg::MagW-1:0]       den_i,
  output cau_pkg::cau_side_t             side_o,
  output logic [cau_pkg::QuoW-1:0]       quo_re_o,
  output logic [cau_pkg::QuoW-1:0]       quo_im_o,
  output logic                           big_re_o,
  output logic                           big_im_o
);

  logic [cau_pkg::MagW-1:0] num [2];
  cau_pkg::cau_side_t       side_q [cau_pkg::DivStages];
  logic [cau_pkg::MagW-1:0] den_q  [cau_pkg::DivStages];
  logic [cau_pkg::MagW-1:0] rem_q  [2][cau_pkg::DivStages];
  logic [cau_pkg::QuoW-1:0] low_q  [2][cau_pkg::DivStages];
  logic [cau_pkg::QuoW-1:0] quo_q  [2][cau_pkg::DivStages];
  logic                     big_q  [2][cau_pkg::DivStages];

  assign num[0] = num_re_i;
  assign num[1] = num_im_i;

  for (genvar i = 0; i < cau_pkg::DivStages; i++) begin : g_stage
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          side_q[i] <= '0;
        end else if (en_i) begin
          side_q[i] <= side_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[i] <= den_i;
        end
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [cau_pkg::NumW-1:0] nfull;
        logic                     big;
        assign nfull = {num[l], {cau_pkg::FracBits{1'b0}}};
        // quotient needs more than the kept bits
        assign big = {{(cau_pkg::CmpW-cau_pkg::NumW){1'b0}}, nfull} >=
                     {den_i, {cau_pkg::QuoW{1'b0}}};
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[l][i] <= cau_pkg::MagW'(nfull[cau_pkg::NumW-1:cau_pkg::QuoW]);
            low_q[l][i] <= nfull[cau_pkg::QuoW-1:0];
            quo_q[l][i] <= '0;
            big_q[l][i] <= big;
          end
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          side_q[i] <= '0;
        end else if (en_i) begin
          side_q[i] <= side_q[i-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[i] <= den_q[i-1];
        end
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [cau_pkg::MagW:0] trial;
        logic [cau_pkg::MagW:0] diff;
        logic                   ge;
        assign trial = {rem_q[l][i-1], low_q[l][i-1][cau_pkg::QuoW-1]};
        assign diff  = trial - {1'b0, den_q[i-1]};
        assign ge    = (trial >= {1'b0, den_q[i-1]});
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[l][i] <= ge ? diff[cau_pkg::MagW-1:0] : trial[cau_pkg::MagW-1:0];
            low_q[l][i] <= {low_q[l][i-1][cau_pkg::QuoW-2:0], 1'b0};
            quo_q[l][i] <= {quo_q[l][i-1][cau_pkg::QuoW-2:0], ge};
            big_q[l][i] <= big_q[l][i-1];
          end
        end
      end
    end
  end

  assign side_o   = side_q[cau_pkg::DivStages-1];
  assign quo_re_o = quo_q[0][cau_pkg::DivStages-1];
  assign quo_im_o = quo_q[1][cau_pkg::DivStages-1];
  assign big_re_o = big_q[0][cau_pkg::DivStages-1];
  assign big_im_o = big_q[1][cau_pkg::DivStages-1];

endmodule

### hw/rtl/cau_back.sv
// back end: products, sums, magnitudes, divider and output register,
// all stages advance together; uses cau_pkg and cau_div
module cau_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  cau_pkg::cau_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cau_pkg::cau_out_t  out_o
);

  logic en;

  // stage 1: products and add/sub
  logic signed [cau_pkg::DataW:0]   as_re;
  logic signed [cau_pkg::DataW:0]   as_im;
  logic [cau_pkg::QuoW-1:0]         as_mag_re;
  logic [cau_pkg::QuoW-1:0]         as_mag_im;
  cau_pkg::cau_sat_t                as_sat_re;
  cau_pkg::cau_sat_t                as_sat_im;
  cau_pkg::cau_side_t               s1_side_d;
  cau_pkg::cau_side_t               s1_side_q;
  logic signed [cau_pkg::ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q;

  // stage 2: sums
  cau_pkg::cau_side_t               s2_side_q;
  logic signed [cau_pkg::SumW-1:0]  sum_re_d, sum_im_d;
  logic signed [cau_pkg::SumW-1:0]  sum_re_q, sum_im_q;
  logic [cau_pkg::MagW-1:0]         den_d, den2_q;

  // stage 3: magnitudes
  logic signed [cau_pkg::SumW-1:0]  ngt_re, ngt_im;
  logic [cau_pkg::MagW-1:0]         mag_re, mag_im;
  logic [cau_pkg::MagW-1:0]         sh_re, sh_im;
  cau_pkg::cau_sat_t                mul_re, mul_im;
  cau_pkg::cau_side_t               s3_side_d, s3_side_q;
  logic [cau_pkg::MagW-1:0]         num_re_q, num_im_q, den3_q;

  // divider and output
  cau_pkg::cau_side_t               dv_side;
  logic [cau_pkg::QuoW-1:0]         quo_re, quo_im;
  logic                             big_re, big_im;
  cau_pkg::cau_sat_t                dv_re, dv_im;
  cau_pkg::cau_out_t                out_d, out_q;
  logic                             out_vld_q;

  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en;

  always_comb begin
    if (item_i.cmd == cau_pkg::CmdSub) begin
      as_re = {item_i.a_re[cau_pkg::DataW-1], item_i.a_re} -
              {item_i.b_re[cau_pkg::DataW-1], item_i.b_re};
      as_im = {item_i.a_im[cau_pkg::DataW-1], item_i.a_im} -
              {item_i.b_im[cau_pkg::DataW-1], item_i.b_im};
    end else begin
      as_re = {item_i.a_re[cau_pkg::DataW-1], item_i.a_re} +
              {item_i.b_re[cau_pkg::DataW-1], item_i.b_re};
      as_im = {item_i.a_im[cau_pkg::DataW-1], item_i.a_im} +
              {item_i.b_im[cau_pkg::DataW-1], item_i.b_im};
    end
    as_mag_re = as_re[cau_pkg::DataW] ? (cau_pkg::QuoW'(0) - as_re) : as_re;
    as_mag_im = as_im[cau_pkg::DataW] ? (cau_pkg::QuoW'(0) - as_im) : as_im;
    as_sat_re = cau_pkg::sat_mag(as_re[cau_pkg::DataW], 1'b0, as_mag_re);
    as_sat_im = cau_pkg::sat_mag(as_im[cau_pkg::DataW], 1'b0, as_mag_im);

    s1_side_d          = '0;
    s1_side_d.valid    = item_valid_i;
    s1_side_d.cmd      = item_i.cmd;
    s1_side_d.div_zero = item_i.div_zero;
    s1_side_d.pre_re   = as_sat_re.val;
    s1_side_d.pre_im   = as_sat_im.val;
    s1_side_d.pre_ovf  = as_sat_re.ovf || as_sat_im.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_rr_q <= item_i.a_re * item_i.b_re;
      p_ii_q <= item_i.a_im * item_i.b_im;
      p_ri_q <= item_i.a_re * item_i.b_im;
      p_ir_q <= item_i.a_im * item_i.b_re;
      p_bb_q <= item_i.b_re * item_i.b_re;
      p_cc_q <= item_i.b_im * item_i.b_im;
    end
  end

  always_comb begin
    if (s1_side_q.cmd == cau_pkg::CmdDiv) begin
      sum_re_d = cau_pkg::SumW'(p_rr_q) + cau_pkg::SumW'(p_ii_q);
      sum_im_d = cau_pkg::SumW'(p_ir_q) - cau_pkg::SumW'(p_ri_q);
    end else begin
      sum_re_d = cau_pkg::SumW'(p_rr_q) - cau_pkg::SumW'(p_ii_q);
      sum_im_d = cau_pkg::SumW'(p_ri_q) + cau_pkg::SumW'(p_ir_q);
    end
    den_d = $unsigned(p_bb_q) + $unsigned(p_cc_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      den2_q   <= den_d;
    end
  end

  always_comb begin
    ngt_re = -sum_re_q;
    ngt_im = -sum_im_q;
    mag_re = sum_re_q[cau_pkg::SumW-1] ? cau_pkg::MagW'(ngt_re) : cau_pkg::MagW'(sum_re_q);
    mag_im = sum_im_q[cau_pkg::SumW-1] ? cau_pkg::MagW'(ngt_im) : cau_pkg::MagW'(sum_im_q);
    sh_re  = mag_re >> cau_pkg::FracBits;
    sh_im  = mag_im >> cau_pkg::FracBits;
    mul_re = cau_pkg::sat_mag(sum_re_q[cau_pkg::SumW-1],
                              |sh_re[cau_pkg::MagW-1:cau_pkg::QuoW],
                              sh_re[cau_pkg::QuoW-1:0]);
    mul_im = cau_pkg::sat_mag(sum_im_q[cau_pkg::SumW-1],
                              |sh_im[cau_pkg::MagW-1:cau_pkg::QuoW],
                              sh_im[cau_pkg::QuoW-1:0]);

    s3_side_d        = s2_side_q;
    s3_side_d.neg_re = sum_re_q[cau_pkg::SumW-1];
    s3_side_d.neg_im = sum_im_q[cau_pkg::SumW-1];
    if (s2_side_q.cmd == cau_pkg::CmdMul) begin
      s3_side_d.pre_re  = mul_re.val;
      s3_side_d.pre_im  = mul_im.val;
      s3_side_d.pre_ovf = mul_re.ovf || mul_im.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_re_q <= mag_re;
      num_im_q <= mag_im;
      den3_q   <= den2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_side_q <= '0;
      s2_side_q <= '0;
      s3_side_q <= '0;
    end else if (en) begin
      s1_side_q <= s1_side_d;
      s2_side_q <= s1_side_q;
      s3_side_q <= s3_side_d;
    end
  end

  cau_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .side_i   (s3_side_q),
    .num_re_i (num_re_q),
    .num_im_i (num_im_q),
    .den_i    (den3_q),
    .side_o   (dv_side),
    .quo_re_o (quo_re),
    .quo_im_o (quo_im),
    .big_re_o (big_re),
    .big_im_o (big_im)
  );

  always_comb begin
    dv_re = cau_pkg::sat_mag(dv_side.neg_re, big_re, quo_re);
    dv_im = cau_pkg::sat_mag(dv_side.neg_im, big_im, quo_im);
    if (dv_side.cmd == cau_pkg::CmdDiv) begin
      if (dv_side.div_zero) begin
        out_d.res_re = '0;
        out_d.res_im = '0;
        out_d.status = cau_pkg::StDivZero;
      end else begin
        out_d.res_re = dv_re.val;
        out_d.res_im = dv_im.val;
        out_d.status = (dv_re.ovf || dv_im.ovf) ? cau_pkg::StOverflow : cau_pkg::StOk;
      end
    end else begin
      out_d.res_re = dv_side.pre_re;
      out_d.res_im = dv_side.pre_im;
      out_d.status = dv_side.pre_ovf ? cau_pkg::StOverflow : cau_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_side.valid;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

### hw/rtl/complex_arith_unit.sv
// complex arithmetic unit top level: front queue plus back pipeline
// uses cau_pkg, cau_front, cau_back
//
//   channel  | valid       | ready       | word
//   ---------+-------------+-------------+-------------------
//   input    | in_valid_i  | in_ready_o  | in_i  (cau_in_t)
//   output   | out_valid_o | out_ready_i | out_o (cau_out_t)
//
// one word per cycle while out_ready_i is high, results in input order
// path from accept to output valid: queue, three arithmetic stages, 34 divider
// stages (a head stage, then one quotient bit each) and the output register
// every command runs the full pipeline; the queue absorbs output stalls
// reset clears the queue and all stage valid bits
module complex_arith_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cau_pkg::cau_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cau_pkg::cau_out_t out_o
);

  logic               item_valid;
  logic               pop;
  cau_pkg::cau_item_t item;

  cau_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cau_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule

### hw/rtl/cau_checker.sv
// port-level checks for the complex arithmetic unit, bound to the top level
// uses cau_pkg and complex_arith_unit_macros.svh
`include "complex_arith_unit_macros.svh"

module cau_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input cau_pkg::cau_in_t  in_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cau_pkg::cau_out_t out_o
);

  logic in_wait;
  logic out_wait;
  logic dz_word;
  logic ovf_word;
  logic dz_zero;
  logic re_clamped;
  logic im_clamped;

  assign in_wait    = in_valid_i && !in_ready_o;
  assign out_wait   = out_valid_o && !out_ready_i;
  assign dz_word    = out_valid_o && (out_o.status == cau_pkg::StDivZero);
  assign ovf_word   = out_valid_o && (out_o.status == cau_pkg::StOverflow);
  assign dz_zero    = (out_o.res_re == '0) && (out_o.res_im == '0);
  assign re_clamped = (out_o.res_re == 32'sh7fffffff) || (out_o.res_re == 32'sh80000000);
  assign im_clamped = (out_o.res_im == 32'sh7fffffff) || (out_o.res_im == 32'sh80000000);

  `CAU_ASSERT_NEXT(a_in_hold, in_wait, in_valid_i && $stable(in_i))
  `CAU_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_o))
  `CAU_ASSERT_SAME(a_dz_zero, dz_word, dz_zero)
  `CAU_ASSERT_SAME(a_ovf_clamped, ovf_word, re_clamped || im_clamped)

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

### bench/complex_arith_unit_tb.sv
// self-checking bench for complex_arith_unit: random and corner words with idle bursts
// depends on cau_pkg and the complex_arith_unit rtl
`timescale 1ns / 100ps

module complex_arith_unit_tb;

  localparam int NumRandom = 1250;
  localparam int MaxCycles = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  cau_pkg::cau_in_t  in_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  cau_pkg::cau_out_t out_o;

  cau_pkg::cau_in_t  pending_words[$];
  cau_pkg::cau_out_t expected_results[$];
  bit       all_sent = 1'b0;
  bit       quiet = 1'b0;
  bit       failed = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       cycle_cnt = 0;

  complex_arith_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  always #2 clk_i = ~clk_i;

  // clamp a signed exact value to the word range
  function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout bit ovf);
    if (v > 128'sh7fffffff) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // fixed point quotient rounded toward zero
  function automatic logic signed [127:0] fix_quot(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
    logic signed [127:0] mag;
    mag = ((num < 0) ? -num : num) * (128'sd1 <<< cau_pkg::FracBits) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [127:0] fix_prod(input logic signed [127:0] v);
    logic signed [127:0] mag;
    mag = ((v < 0) ? -v : v) >>> cau_pkg::FracBits;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic cau_pkg::cau_out_t complex_result(input cau_pkg::cau_in_t w);
    cau_pkg::cau_out_t r;
    bit ovf;
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    ovf = 1'b0;
    ar = w.a_re;
    ai = w.a_im;
    br = w.b_re;
    bi = w.b_im;
    case (w.command)
      cau_pkg::CmdAdd: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::CmdSub: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::CmdMul: begin
        re = fix_prod(ar * br - ai * bi);
        im = fix_prod(ar * bi + ai * br);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.res_re = '0;
          r.res_im = '0;
          r.status = cau_pkg::StDivZero;
          return r;
        end
        re = fix_quot(ar * br + ai * bi, den);
        im = fix_quot(ai * br - ar * bi, den);
      end
    endcase
    r.res_re = clamp_word(re, ovf);
    r.res_im = clamp_word(im, ovf);
    r.status = ovf ? cau_pkg::StOverflow : cau_pkg::StOk;
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 8)) - 4) << cau_pkg::FracBits;
      3: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      4: return '0;
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input cau_pkg::cmd_e c, input logic [31:0] ar, ai, br, bi);
    cau_pkg::cau_in_t w;
    w.command = c;
    w.a_re = ar;
    w.a_im = ai;
    w.b_re = br;
    w.b_im = bi;
    pending_words.push_back(w);
  endtask

  initial begin
    cau_pkg::cmd_e c;
    for (int k = 0; k < 4; k++) begin
      c = cau_pkg::cmd_e'(k);
      push_word(c, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      push_word(c, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      push_word(c, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
      push_word(c, 32'h12345678, 32'hedcba987, 32'h0, 32'h0);
    end
    push_word(cau_pkg::CmdDiv, 32'h0, 32'h0, 32'h0, 32'h0);
    push_word(cau_pkg::CmdDiv, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 32'h0);
    push_word(cau_pkg::CmdDiv, 32'h00030000, 32'hfffc0000, 32'h0, 32'h00000003);
    push_word(cau_pkg::CmdMul, 32'h80000000, 32'h0, 32'h80000000, 32'h0);
    push_word(cau_pkg::CmdMul, 32'hffffffff, 32'h1, 32'h1, 32'h1);
    for (int n = 0; n < NumRandom; n++) begin
      push_word(cau_pkg::cmd_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    quiet <= pending_words.size() < 150;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(complex_result(in_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
          in_valid_i <= 1'b0;
          all_sent <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cau_pkg::cau_out_t exp_word;
    bit bad;
    bad = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected word: res_re %h res_im %h", out_o.res_re, out_o.res_im);
          bad = 1'b1;
        end else begin
          exp_word = expected_results.pop_front();
          if (out_o.res_re !== exp_word.res_re) begin
            $error("res_re expected %h actual %h", exp_word.res_re, out_o.res_re);
            bad = 1'b1;
          end
          if (out_o.res_im !== exp_word.res_im) begin
            $error("res_im expected %h actual %h", exp_word.res_im, out_o.res_im);
            bad = 1'b1;
          end
          if (out_o.status !== exp_word.status) begin
            $error("status expected %0d actual %0d", exp_word.status, out_o.status);
            bad = 1'b1;
          end
        end
      end
      if (bad) failed <= 1'b1;
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 18);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    wait (all_sent && !in_valid_i && expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    if (!failed && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
